// ----- src/hsc_pkg.sv -----
// Shared constants, types and the slot hash for the hashed sector cache.
package hsc_pkg;

    localparam int SLOTS        = 128;
    localparam int SECTOR_WORDS = 64;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int WORD_W  = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
    localparam int CNT_W   = $clog2(SECTOR_WORDS + 1);
    localparam int ADDR_W  = (SLOTS * SECTOR_WORDS > 1) ? $clog2(SLOTS * SECTOR_WORDS) : 1;

    localparam int DRV_W   = 2;
    localparam int BLK_W   = 32;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 64;
    localparam int MODE_W  = 2;
    localparam int TAG_W   = DRV_W + BLK_W;

    localparam int S_TDATA_W = 104;  // drive, block, pos, data: 13 bytes
    localparam int M_TDATA_W = 72;   // data_out, word_out_pos, padded to 9 bytes

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVAL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic ready;
        logic capture;
        logic insert;
        logic inval;
        logic load_miss;
        logic stream_start;
        logic streaming;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_lookup;
        logic in_inval;
        logic in_insert;
        logic tag_hit;
        logic out_free;
        logic stream_done;
    } t_sts;

    // Low bits of (blk * HASH_MULT + drv) only depend on the low bits of blk.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [DRV_W-1:0] drv,
                                                  input logic [BLK_W-1:0] blk);
        logic [2*SLOT_W-1:0] prod;
        prod = blk[SLOT_W-1:0] * HASH_MULT[SLOT_W-1:0];
        return prod[SLOT_W-1:0] + SLOT_W'(drv);
    endfunction

endpackage

// ----- src/hsc_ctrl.sv -----
// Controller state machine for the hashed sector cache.
module hsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hsc_pkg::t_sts i_sts,
    output hsc_pkg::t_cmd o_cmd
);
    import hsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STREAM
    } t_state;

    t_state r_state, n_state;
    logic   r_is_lookup, n_is_lookup;
    t_cmd   cmd;
    logic   accept;

    assign accept = i_sts.in_valid && (r_state == ST_IDLE);

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_is_lookup = r_is_lookup;
        unique case (r_state)
            ST_IDLE: begin
                cmd.ready = 1'b1;
                if (accept) begin
                    if (i_sts.in_lookup || i_sts.in_inval) begin
                        cmd.capture = 1'b1;
                        n_is_lookup = i_sts.in_lookup;
                        n_state     = ST_CHECK;
                    end else if (i_sts.in_insert) begin
                        cmd.insert = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (!r_is_lookup) begin
                    cmd.inval = i_sts.tag_hit;
                    n_state   = ST_IDLE;
                end else if (i_sts.tag_hit) begin
                    cmd.stream_start = 1'b1;
                    n_state          = ST_STREAM;
                end else if (i_sts.out_free) begin
                    cmd.load_miss = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_STREAM: begin
                cmd.streaming = 1'b1;
                if (i_sts.stream_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_is_lookup <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_is_lookup <= n_is_lookup;
        end
    end

    assign o_cmd = cmd;

endmodule

// ----- src/hsc_dp.sv -----
// Datapath: tag and sector memories, valid flags, read pipe and output register.
module hsc_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hsc_pkg::t_cmd                  i_cmd,
    output hsc_pkg::t_sts                  o_sts,
    input  logic                           i_in_valid,
    input  logic [hsc_pkg::MODE_W-1:0]     i_in_mode,
    input  logic [hsc_pkg::DRV_W-1:0]      i_in_drv,
    input  logic [hsc_pkg::BLK_W-1:0]      i_in_blk,
    input  logic [hsc_pkg::POS_W-1:0]      i_in_pos,
    input  logic [hsc_pkg::DATA_W-1:0]     i_in_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_out_hit,
    output logic [hsc_pkg::DATA_W-1:0]     o_out_data,
    output logic [hsc_pkg::POS_W-1:0]      o_out_pos,
    output logic                           o_out_last
);
    import hsc_pkg::*;

    logic [TAG_W-1:0]  mem_tag  [SLOTS];
    logic [DATA_W-1:0] mem_data [SLOTS*SECTOR_WORDS];

    logic [SLOTS-1:0]  r_valid;
    logic [SLOTS-1:0]  r_tag_set;  // tag entry written since reset; else it reads as zero
    logic [SLOT_W-1:0] r_slot;
    logic [TAG_W-1:0]  r_key;
    logic [TAG_W-1:0]  r_tag_rd;

    logic [DATA_W-1:0] r_rdata;
    logic [CNT_W-1:0]  r_rd_cnt;   // words read so far
    logic [CNT_W-1:0]  r_rd_pos;   // position of the word in r_rdata
    logic              r_rd_vld;

    logic              r_out_valid, r_out_hit, r_out_last;
    logic [DATA_W-1:0] r_out_data;
    logic [POS_W-1:0]  r_out_pos;

    logic [SLOT_W-1:0] in_slot;
    logic              pos_ok, pos_first, pos_final;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CNT_W-1:0]  issue_idx;
    logic [TAG_W-1:0]  tag_eff;
    logic              out_free, load, issue, rd_final, tag_hit;

    assign in_slot   = slot_of(i_in_drv, i_in_blk);
    assign pos_ok    = 32'(i_in_pos) < 32'(SECTOR_WORDS);
    assign pos_first = (i_in_pos == '0);
    assign pos_final = 32'(i_in_pos) == 32'(SECTOR_WORDS - 1);
    assign wr_addr   = ADDR_W'(in_slot) * ADDR_W'(SECTOR_WORDS) + ADDR_W'(i_in_pos);

    assign tag_eff   = r_tag_set[r_slot] ? r_tag_rd : '0;
    assign tag_hit   = r_valid[r_slot] && (tag_eff == r_key);
    assign out_free  = !r_out_valid || i_out_ready;
    assign load      = i_cmd.streaming && r_rd_vld && out_free;
    assign rd_final  = (r_rd_pos == CNT_W'(SECTOR_WORDS - 1));
    assign issue_idx = i_cmd.stream_start ? '0 : r_rd_cnt;
    assign issue     = i_cmd.stream_start ||
                       (i_cmd.streaming && (r_rd_cnt < CNT_W'(SECTOR_WORDS)) &&
                        (!r_rd_vld || load));
    assign rd_addr   = ADDR_W'(r_slot) * ADDR_W'(SECTOR_WORDS) + ADDR_W'(issue_idx);

    // tag memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && pos_ok && pos_first) begin
            mem_tag[in_slot] <= {i_in_drv, i_in_blk};
        end
        if (i_cmd.capture) begin
            r_tag_rd <= mem_tag[in_slot];
        end
    end

    // sector memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && pos_ok) begin
            mem_data[wr_addr] <= i_in_data;
        end
        if (issue) begin
            r_rdata <= mem_data[rd_addr];
        end
    end

    // key capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot <= in_slot;
            r_key  <= {i_in_drv, i_in_blk};
        end
        if (issue) begin
            r_rd_pos <= issue_idx;
            r_rd_cnt <= issue_idx + CNT_W'(1);
        end
    end

    // valid flags; a final word sets valid after the first word cleared it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_tag_set <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.insert && pos_ok) begin
                if (pos_first) begin
                    r_tag_set[in_slot] <= 1'b1;
                end
                if (pos_final) begin
                    r_valid[in_slot] <= 1'b1;
                end else if (pos_first) begin
                    r_valid[in_slot] <= 1'b0;
                end
            end
            if (i_cmd.inval) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (load) begin
                r_rd_vld <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load || i_cmd.load_miss) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_hit  <= 1'b1;
            r_out_data <= r_rdata;
            r_out_pos  <= POS_W'(r_rd_pos);
            r_out_last <= rd_final;
        end else if (i_cmd.load_miss) begin
            r_out_hit  <= 1'b0;
            r_out_data <= '0;
            r_out_pos  <= '0;
            r_out_last <= 1'b1;
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.in_valid    = i_in_valid;
        o_sts.in_lookup   = (i_in_mode == MODE_LOOKUP);
        o_sts.in_inval    = (i_in_mode == MODE_INVAL);
        o_sts.in_insert   = (i_in_mode == MODE_INSERT);
        o_sts.tag_hit     = tag_hit;
        o_sts.out_free    = out_free;
        o_sts.stream_done = load && rd_final;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;
    assign o_out_data  = r_out_data;
    assign o_out_pos   = r_out_pos;
    assign o_out_last  = r_out_last;

endmodule

// ----- src/hashed_sector_cache_core.sv -----
// Top level of the hashed sector cache: stream ports, controller and datapath.
//
//  channel   dir  tuser                  tdata (low bit up)                      tlast
//  s (in)    in   mode[1:0]              drive_id, block_addr, word_pos, data_in   -
//  m (out)   out  hit                    data_out, word_out_pos, 2 pad bits        last
//
// Direct-mapped cache of sectors; slot = low bits of block_addr*2654435761+drive_id.
// Handling: an insert word or an ignored word (mode 3 or word_pos past the sector)
//   is taken in ST_IDLE. Invalidate reads the tag memory, then compares in ST_CHECK.
//   Lookup reads the tag memory, then decides hit/miss in ST_CHECK; a hit then streams
//   SECTOR_WORDS words, one per cycle unless m stalls, paced by the single sector read port.
// Reset clears the valid flags; there is no clearing pass over memory.
// Stalls on the m side hold the output word; s_tready stays low until the
// lookup run has been handed to the output register.
module hashed_sector_cache_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [hsc_pkg::S_TDATA_W-1:0]     i_s_tdata,  // drive_id, block_addr, word_pos, data_in
    input  logic [hsc_pkg::MODE_W-1:0]        i_s_tuser,  // mode
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [hsc_pkg::M_TDATA_W-1:0]     o_m_tdata,  // data_out, word_out_pos, zero pad
    output logic                              o_m_tuser,  // hit
    output logic                              o_m_tlast
);
    import hsc_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [DATA_W-1:0] out_data;
    logic [POS_W-1:0]  out_pos;

    hsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (i_s_tvalid),
        .i_in_mode   (i_s_tuser),
        .i_in_drv    (i_s_tdata[1:0]),
        .i_in_blk    (i_s_tdata[33:2]),
        .i_in_pos    (i_s_tdata[39:34]),
        .i_in_data   (i_s_tdata[103:40]),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_hit   (o_m_tuser),
        .o_out_data  (out_data),
        .o_out_pos   (out_pos),
        .o_out_last  (o_m_tlast)
    );

    assign o_s_tready = cmd.ready;
    assign o_m_tdata  = {2'b00, out_pos, out_data};

endmodule
